>>> design/atw_pkg.sv
// ----------------------------------------------------------------------------
// atw_pkg
// Shared types and codes for the active timestamp watermark core.
// ----------------------------------------------------------------------------
package atw_pkg;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_COMMIT = 2'd2;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [1:0] STAT_FULL      = 2'd2;
   localparam logic [1:0] STAT_SATURATED = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] timestamp;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] watermark;
      logic [31:0] latest_commit;
      logic [4:0]  active_entries;
      logic [1:0]  status;
   } rsp_payload_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic set_valid;
      logic clr_valid;
   } tbl_ctl_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_UPDATE,
      S_MIN,
      S_DONE
   } state_type;

endpackage

>>> design/atw_table.sv
// ----------------------------------------------------------------------------
// atw_table
// Entry store: stamp and reference count memory with one read and one write
// port, plus per-entry valid flags cleared by reset.
// ----------------------------------------------------------------------------
module atw_table #(
   parameter int ENTRIES    = 16,
   parameter int TS_BITS    = 32,
   parameter int COUNT_BITS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  atw_pkg::tbl_ctl_type        ctl,
   input  logic [$clog2(ENTRIES)-1:0]  rd_addr,
   input  logic [$clog2(ENTRIES)-1:0]  wr_addr,
   input  logic [TS_BITS-1:0]          wr_stamp,
   input  logic [COUNT_BITS-1:0]       wr_refs,
   output logic                        rd_valid,
   output logic [TS_BITS-1:0]          rd_stamp,
   output logic [COUNT_BITS-1:0]       rd_refs
);
   import atw_pkg::*;

   localparam int WORD_W = TS_BITS + COUNT_BITS;

   logic [WORD_W-1:0]  mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [WORD_W-1:0]  rd_data_ff;
   logic               rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= {wr_stamp, wr_refs};
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ctl.set_valid) begin
            valid_ff[wr_addr] <= 1'b1;
         end else if (ctl.clr_valid) begin
            valid_ff[wr_addr] <= 1'b0;
         end
         if (ctl.rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_stamp = rd_data_ff[WORD_W-1:COUNT_BITS];
   assign rd_refs  = rd_data_ff[COUNT_BITS-1:0];

endmodule

>>> design/atw_ctrl.sv
// ----------------------------------------------------------------------------
// atw_ctrl
// Sequencer: scans the entry table one entry per cycle through a shared
// compare unit, applies the command, and recomputes the watermark.
// ----------------------------------------------------------------------------
module atw_ctrl #(
   parameter int ENTRIES    = 16,
   parameter int TS_BITS    = 32,
   parameter int COUNT_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  atw_pkg::req_payload_type     start_data,
   input  logic                         out_free,
   output logic                         idle,
   output logic                         done,
   output atw_pkg::rsp_payload_type     result,
   output atw_pkg::tbl_ctl_type         tbl_ctl,
   output logic [$clog2(ENTRIES)-1:0]   tbl_rd_addr,
   output logic [$clog2(ENTRIES)-1:0]   tbl_wr_addr,
   output logic [TS_BITS-1:0]           tbl_wr_stamp,
   output logic [COUNT_BITS-1:0]        tbl_wr_refs,
   input  logic                         tbl_rd_valid,
   input  logic [TS_BITS-1:0]           tbl_rd_stamp,
   input  logic [COUNT_BITS-1:0]        tbl_rd_refs
);
   import atw_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = IDX_W + 1;
   localparam logic [CNT_W-1:0]      ENTRIES_C = CNT_W'(ENTRIES);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   state_type              state_ff, state_in;
   logic [1:0]             cmd_ff, cmd_in;
   logic [TS_BITS-1:0]     ts_ff, ts_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   pend_ff, pend_in;
   logic [IDX_W-1:0]       pend_idx_ff, pend_idx_in;
   logic                   match_ff, match_in;
   logic [IDX_W-1:0]       match_idx_ff, match_idx_in;
   logic [COUNT_BITS-1:0]  match_refs_ff, match_refs_in;
   logic                   free_ff, free_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;
   logic                   any_ff, any_in;
   logic [TS_BITS-1:0]     best_ff, best_in;
   logic [TS_BITS-1:0]     commit_ff, commit_in;
   logic [TS_BITS-1:0]     low_ff, low_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [1:0]             status_ff, status_in;

   logic                   scanning;
   logic                   issue;
   logic                   scan_end;
   logic [TS_BITS-1:0]     cmp_a;
   logic [TS_BITS-1:0]     cmp_b;
   logic                   cmp_eq;
   logic                   cmp_lt;
   logic [COUNT_BITS-1:0]  refs_dec;
   logic                   do_inc;
   logic                   do_insert;
   logic                   do_dec;
   logic                   do_free;
   logic [TS_BITS-1:0]     commit_new;

   assign scanning = (state_ff == S_SCAN) || (state_ff == S_MIN);
   assign issue    = scanning && (cnt_ff != ENTRIES_C);
   assign scan_end = (cnt_ff == ENTRIES_C) && !pend_ff;

   // shared compare unit
   always_comb begin
      cmp_a = ts_ff;
      cmp_b = low_ff;
      if (state_ff == S_SCAN) begin
         cmp_a = tbl_rd_stamp;
         cmp_b = ts_ff;
      end else if (state_ff == S_MIN) begin
         cmp_a = tbl_rd_stamp;
         cmp_b = best_ff;
      end
   end

   assign cmp_eq = (cmp_a == cmp_b);
   assign cmp_lt = (cmp_a < cmp_b);

   // command decode for the update cycle
   always_comb begin
      refs_dec  = (match_refs_ff != '0) ? match_refs_ff - COUNT_ONE : '0;
      do_inc    = 1'b0;
      do_insert = 1'b0;
      do_dec    = 1'b0;
      do_free   = 1'b0;
      if (state_ff == S_UPDATE) begin
         if (cmd_ff == CMD_ADD) begin
            do_inc    = match_ff && (match_refs_ff != COUNT_MAX);
            do_insert = !match_ff && free_ff;
         end else if (cmd_ff == CMD_REMOVE) begin
            do_dec  = match_ff && (refs_dec != '0);
            do_free = match_ff && (refs_dec == '0);
         end
      end
      commit_new = (ts_ff > commit_ff) ? ts_ff : commit_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if ((start_data.cmd == CMD_ADD) || (start_data.cmd == CMD_REMOVE)) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_UPDATE;
               end
            end
         end
         S_SCAN: begin
            if (scan_end) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            state_in = do_free ? S_MIN : S_DONE;
         end
         S_MIN: begin
            if (scan_end) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      tbl_ctl           = '0;
      tbl_ctl.rd_en     = issue;
      tbl_ctl.wr_en     = do_inc || do_insert || do_dec;
      tbl_ctl.set_valid = do_insert;
      tbl_ctl.clr_valid = do_free;
      tbl_rd_addr       = cnt_ff[IDX_W-1:0];
      tbl_wr_addr       = do_insert ? free_idx_ff : match_idx_ff;
      tbl_wr_stamp      = ts_ff;
      tbl_wr_refs       = COUNT_ONE;
      if (do_inc) begin
         tbl_wr_refs = match_refs_ff + COUNT_ONE;
      end else if (do_dec) begin
         tbl_wr_refs = refs_dec;
      end
      idle                  = (state_ff == S_IDLE);
      done                  = (state_ff == S_DONE) && out_free;
      result.watermark      = 32'(low_ff);
      result.latest_commit  = 32'(commit_ff);
      result.active_entries = 5'(count_ff);
      result.status         = status_ff;
   end

   // datapath
   always_comb begin
      cmd_in        = cmd_ff;
      ts_in         = ts_ff;
      cnt_in        = cnt_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      match_in      = match_ff;
      match_idx_in  = match_idx_ff;
      match_refs_in = match_refs_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      any_in        = any_ff;
      best_in       = best_ff;
      commit_in     = commit_ff;
      low_in        = low_ff;
      count_in      = count_ff;
      status_in     = status_ff;

      if ((state_ff == S_IDLE) && start) begin
         cmd_in    = start_data.cmd;
         ts_in     = TS_BITS'(start_data.timestamp);
         cnt_in    = '0;
         pend_in   = 1'b0;
         match_in  = 1'b0;
         free_in   = 1'b0;
         status_in = STAT_OK;
      end

      if (scanning) begin
         pend_in     = issue;
         pend_idx_in = cnt_ff[IDX_W-1:0];
         if (issue) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
         if (pend_ff) begin
            if (state_ff == S_SCAN) begin
               if (tbl_rd_valid && cmp_eq) begin
                  match_in      = 1'b1;
                  match_idx_in  = pend_idx_ff;
                  match_refs_in = tbl_rd_refs;
               end
               if (!tbl_rd_valid && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = pend_idx_ff;
               end
            end else if (tbl_rd_valid && (!any_ff || cmp_lt)) begin
               any_in  = 1'b1;
               best_in = tbl_rd_stamp;
            end
         end
         if ((state_ff == S_MIN) && scan_end) begin
            low_in = any_ff ? best_ff : commit_ff;
         end
      end

      if (state_ff == S_UPDATE) begin
         if (cmd_ff == CMD_ADD) begin
            if (match_ff) begin
               if (!do_inc) begin
                  status_in = STAT_SATURATED;
               end
            end else if (!free_ff) begin
               status_in = STAT_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
               if ((count_ff == '0) || cmp_lt) begin
                  low_in = ts_ff;
               end
            end
         end else if (cmd_ff == CMD_REMOVE) begin
            if (!match_ff) begin
               status_in = STAT_NOT_FOUND;
            end else if (do_free) begin
               count_in = count_ff - CNT_W'(1);
               cnt_in   = '0;
               pend_in  = 1'b0;
               any_in   = 1'b0;
            end
         end else if (cmd_ff == CMD_COMMIT) begin
            commit_in = commit_new;
            if ((count_ff == '0) && (commit_new > low_ff)) begin
               low_in = commit_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         pend_ff   <= 1'b0;
         cnt_ff    <= '0;
         commit_ff <= '0;
         low_ff    <= '0;
         count_ff  <= '0;
         status_ff <= STAT_OK;
      end else begin
         state_ff  <= state_in;
         pend_ff   <= pend_in;
         cnt_ff    <= cnt_in;
         commit_ff <= commit_in;
         low_ff    <= low_in;
         count_ff  <= count_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      ts_ff         <= ts_in;
      pend_idx_ff   <= pend_idx_in;
      match_ff      <= match_in;
      match_idx_ff  <= match_idx_in;
      match_refs_ff <= match_refs_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      any_ff        <= any_in;
      best_ff       <= best_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ENTRIES_C)
      else $error("active entry count exceeds table size");

   a_commit_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> commit_ff >= $past(commit_ff))
      else $error("commit timestamp decreased");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == S_IDLE)
      else $error("transaction started while busy");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && status_ff == STAT_FULL) |-> count_ff == ENTRIES_C)
      else $error("table full reported with free entries");

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      $countones({do_inc, do_insert, do_dec, do_free}) <= 1)
      else $error("conflicting table updates");
`endif

endmodule

>>> design/active_timestamp_watermark_core.sv
// ----------------------------------------------------------------------------
// active_timestamp_watermark_core
// Low watermark tracker for multi-version garbage collection. Keeps up to
// ENTRIES distinct active read timestamps with reference counts, the latest
// commit timestamp and the watermark, and returns one result per transaction.
// Add and remove transactions scan the single read port of the entry memory
// one entry per cycle, once to find the timestamp and a free slot, and a
// remove that frees an entry scans it once more to find the new minimum.
// Commit updates and unused commands need no scan. One transaction is
// processed at a time; a finished result waits in the output register while
// the next transaction is accepted.
// ----------------------------------------------------------------------------
module active_timestamp_watermark_core #(
   parameter int ENTRIES    = 16,
   parameter int TS_BITS    = 32,
   parameter int COUNT_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  atw_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output atw_pkg::rsp_payload_type rsp_data
);
   import atw_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);

   logic                   idle;
   logic                   done;
   logic                   out_free;
   rsp_payload_type        result;
   tbl_ctl_type            tbl_ctl;
   logic [IDX_W-1:0]       tbl_rd_addr;
   logic [IDX_W-1:0]       tbl_wr_addr;
   logic [TS_BITS-1:0]     tbl_wr_stamp;
   logic [COUNT_BITS-1:0]  tbl_wr_refs;
   logic                   tbl_rd_valid;
   logic [TS_BITS-1:0]     tbl_rd_stamp;
   logic [COUNT_BITS-1:0]  tbl_rd_refs;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   assign req_ready = idle;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   atw_ctrl #(
      .ENTRIES    (ENTRIES),
      .TS_BITS    (TS_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (req_valid && req_ready),
      .start_data   (req_data),
      .out_free     (out_free),
      .idle         (idle),
      .done         (done),
      .result       (result),
      .tbl_ctl      (tbl_ctl),
      .tbl_rd_addr  (tbl_rd_addr),
      .tbl_wr_addr  (tbl_wr_addr),
      .tbl_wr_stamp (tbl_wr_stamp),
      .tbl_wr_refs  (tbl_wr_refs),
      .tbl_rd_valid (tbl_rd_valid),
      .tbl_rd_stamp (tbl_rd_stamp),
      .tbl_rd_refs  (tbl_rd_refs)
   );

   atw_table #(
      .ENTRIES    (ENTRIES),
      .TS_BITS    (TS_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .ctl      (tbl_ctl),
      .rd_addr  (tbl_rd_addr),
      .wr_addr  (tbl_wr_addr),
      .wr_stamp (tbl_wr_stamp),
      .wr_refs  (tbl_wr_refs),
      .rd_valid (tbl_rd_valid),
      .rd_stamp (tbl_rd_stamp),
      .rd_refs  (tbl_rd_refs)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
